FILE: rtl/core/integer_to_decimal_ascii_macros.svh
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii assertion macros
// Concurrent assertion helpers used by the converter's top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_DECIMAL_ASCII_MACROS_SVH
`define INTEGER_TO_DECIMAL_ASCII_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked out of reset.
`define I2DA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");
// Next-cycle implication, checked out of reset.
`define I2DA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define I2DA_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define I2DA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/core/i2da_pkg.sv
// ----------------------------------------------------------------------------
// i2da_pkg
// Types and constants of the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package i2da_pkg;

	// Widths of the number and of its decimal form.
	localparam int VALUE_W         = 32;
	localparam int DIGITS          = 10;
	localparam int BCD_W           = 4 * DIGITS;
	localparam int SR_W            = BCD_W + VALUE_W;
	localparam int WANT_W          = 4;
	localparam int STEPS_PER_STAGE = 8;
	localparam int DABBLE_STAGES   = VALUE_W / STEPS_PER_STAGE;

	// Character codes.
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;

	// Input word: one number to convert.
	typedef struct packed {
		logic [VALUE_W-1:0] value_bits;
		logic               signed_mode;
		logic [WANT_W-1:0]  min_digits;
	} in_word_t;

	// Output word: one character.
	typedef struct packed {
		logic [7:0] char_out;
		logic       last_char;
	} out_word_t;

	// Word moving through the conversion pipeline.
	typedef struct packed {
		logic              neg;
		logic [WANT_W-1:0] want;
		logic [SR_W-1:0]   sr;
	} pipe_t;

endpackage

FILE: rtl/core/i2da_front.sv
// ----------------------------------------------------------------------------
// i2da_front
// First pipeline stage: sign, magnitude and clamped minimum digit count.
// ----------------------------------------------------------------------------
module i2da_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              up_valid,
	input  i2da_pkg::in_word_t up_word,
	output logic              up_stall,
	output logic              dn_valid,
	output i2da_pkg::pipe_t   dn_word,
	input  logic              dn_stall
);

	logic            valid_s1;
	i2da_pkg::pipe_t word_s1;
	i2da_pkg::pipe_t next_word;

	// Take the magnitude in unsigned arithmetic and clamp the minimum to 1..10.
	always_comb begin
		next_word.neg = up_word.signed_mode & up_word.value_bits[i2da_pkg::VALUE_W-1];
		next_word.sr  = '0;
		if (next_word.neg) begin
			next_word.sr[i2da_pkg::VALUE_W-1:0] = (~up_word.value_bits) + 1'b1;
		end else begin
			next_word.sr[i2da_pkg::VALUE_W-1:0] = up_word.value_bits;
		end
		if (up_word.min_digits == '0) begin
			next_word.want = i2da_pkg::WANT_W'(1);
		end else if (up_word.min_digits > i2da_pkg::WANT_W'(i2da_pkg::DIGITS)) begin
			next_word.want = i2da_pkg::WANT_W'(i2da_pkg::DIGITS);
		end else begin
			next_word.want = up_word.min_digits;
		end
	end

	assign up_stall = valid_s1 & dn_stall;

	// Stage valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!up_stall) begin
			valid_s1 <= up_valid;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (!up_stall) begin
			word_s1 <= next_word;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_word  = word_s1;

endmodule

FILE: rtl/core/i2da_dabble.sv
// ----------------------------------------------------------------------------
// i2da_dabble
// One pipeline stage of the shift-and-add-3 binary to BCD conversion,
// eight bit steps per stage.
// ----------------------------------------------------------------------------
module i2da_dabble (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            up_valid,
	input  i2da_pkg::pipe_t up_word,
	output logic            up_stall,
	output logic            dn_valid,
	output i2da_pkg::pipe_t dn_word,
	input  logic            dn_stall
);

	logic            valid_q;
	i2da_pkg::pipe_t word_q;
	logic [i2da_pkg::SR_W-1:0] next_sr;

	// Per step: add three to every BCD digit of five or more, then shift left.
	always_comb begin
		logic [i2da_pkg::SR_W-1:0] sr;
		sr = up_word.sr;
		for (int s = 0; s < i2da_pkg::STEPS_PER_STAGE; s++) begin
			for (int d = 0; d < i2da_pkg::DIGITS; d++) begin
				if (sr[i2da_pkg::VALUE_W + 4*d +: 4] >= 4'd5) begin
					sr[i2da_pkg::VALUE_W + 4*d +: 4] = sr[i2da_pkg::VALUE_W + 4*d +: 4] + 4'd3;
				end
			end
			sr = {sr[i2da_pkg::SR_W-2:0], 1'b0};
		end
		next_sr = sr;
	end

	assign up_stall = valid_q & dn_stall;

	// Stage valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!up_stall) begin
			valid_q <= up_valid;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (!up_stall) begin
			word_q.neg  <= up_word.neg;
			word_q.want <= up_word.want;
			word_q.sr   <= next_sr;
		end
	end

	assign dn_valid = valid_q;
	assign dn_word  = word_q;

endmodule

FILE: rtl/core/i2da_emit.sv
// ----------------------------------------------------------------------------
// i2da_emit
// Character serializer: takes one converted number, then sends its sign and
// digits one word per cycle, unless the output stalls, through an output register.
// ----------------------------------------------------------------------------
module i2da_emit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                up_valid,
	input  i2da_pkg::pipe_t     up_word,
	output logic                up_stall,
	output logic                dn_valid,
	output i2da_pkg::out_word_t dn_word,
	input  logic                dn_stall
);

	logic                       busy_q;
	logic                       neg_q;
	logic [i2da_pkg::WANT_W-1:0] cnt_q;
	logic [i2da_pkg::BCD_W-1:0]  bcd_q;
	logic                       out_valid_q;
	i2da_pkg::out_word_t        out_q;

	logic [i2da_pkg::WANT_W-1:0] sig;
	logic [i2da_pkg::WANT_W-1:0] ndig;
	logic [i2da_pkg::WANT_W-1:0] idx;
	logic [3:0]                  digit;
	logic                        load;
	logic                        advance;

	// Significant digit count of the incoming number, at least one.
	always_comb begin
		sig = i2da_pkg::WANT_W'(1);
		for (int i = 1; i < i2da_pkg::DIGITS; i++) begin
			if (up_word.sr[i2da_pkg::VALUE_W + 4*i +: 4] != 4'd0) begin
				sig = i2da_pkg::WANT_W'(i + 1);
			end
		end
		ndig = (sig > up_word.want) ? sig : up_word.want;
	end

	assign up_stall = busy_q;
	assign load     = up_valid & ~busy_q;
	assign advance  = busy_q & (~out_valid_q | ~dn_stall);
	assign idx      = cnt_q - 1'b1;
	assign digit    = bcd_q[{idx, 2'b00} +: 4];

	// Control: busy flag, sign pending, digits left, output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			neg_q       <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				neg_q  <= up_word.neg;
				cnt_q  <= ndig;
			end else if (advance) begin
				if (neg_q) begin
					neg_q <= 1'b0;
				end else begin
					cnt_q <= idx;
					if (cnt_q == i2da_pkg::WANT_W'(1)) begin
						busy_q <= 1'b0;
					end
				end
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!dn_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload: digit store and output character.
	always_ff @(posedge clk) begin
		if (load) begin
			bcd_q <= up_word.sr[i2da_pkg::SR_W-1:i2da_pkg::VALUE_W];
		end
		if (advance) begin
			if (neg_q) begin
				out_q.char_out  <= i2da_pkg::CHAR_MINUS;
				out_q.last_char <= 1'b0;
			end else begin
				out_q.char_out  <= i2da_pkg::CHAR_ZERO + {4'd0, digit};
				out_q.last_char <= (cnt_q == i2da_pkg::WANT_W'(1));
			end
		end
	end

	assign dn_valid = out_valid_q;
	assign dn_word  = out_q;

endmodule

FILE: rtl/core/integer_to_decimal_ascii.sv
// A number enters on the num channel and leaves as its decimal ASCII text on
// the chr channel, one character per word, most significant first, with the
// final character flagged. A new number can be taken every cycle, unless the
// pipeline is stalled, into a five-stage pipeline (sign and magnitude, then
// four shift-and-add-3 stages of eight bits each); the character serializer
// at the end takes the next number only after it has sent every character
// of the previous one, and stalls the pipeline meanwhile.
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii
// Converts a signed or unsigned 32-bit integer to zero-padded decimal text.
// ----------------------------------------------------------------------------
`include "integer_to_decimal_ascii_macros.svh"

module integer_to_decimal_ascii (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                num_valid,
	input  i2da_pkg::in_word_t  num,
	output logic                num_stall,
	output logic                chr_valid,
	output i2da_pkg::out_word_t chr,
	input  logic                chr_stall
);

	logic            stg_valid [0:i2da_pkg::DABBLE_STAGES];
	i2da_pkg::pipe_t stg_word  [0:i2da_pkg::DABBLE_STAGES];
	logic            stg_stall [0:i2da_pkg::DABBLE_STAGES];
	logic            emit_valid;
	logic            emit_stall;

	// Sign and magnitude stage.
	i2da_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (num_valid),
		.up_word  (num),
		.up_stall (num_stall),
		.dn_valid (stg_valid[0]),
		.dn_word  (stg_word[0]),
		.dn_stall (stg_stall[0])
	);

	// Binary to BCD stages.
	for (genvar k = 0; k < i2da_pkg::DABBLE_STAGES; k++) begin : g_dabble
		i2da_dabble u_dabble (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (stg_valid[k]),
			.up_word  (stg_word[k]),
			.up_stall (stg_stall[k]),
			.dn_valid (stg_valid[k+1]),
			.dn_word  (stg_word[k+1]),
			.dn_stall (stg_stall[k+1])
		);
	end

	// Handshake between the last BCD stage and the serializer.
	assign emit_valid = stg_valid[i2da_pkg::DABBLE_STAGES];
	assign stg_stall[i2da_pkg::DABBLE_STAGES] = emit_stall;

	// Character serializer.
	i2da_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (emit_valid),
		.up_word  (stg_word[i2da_pkg::DABBLE_STAGES]),
		.up_stall (emit_stall),
		.dn_valid (chr_valid),
		.dn_word  (chr),
		.dn_stall (chr_stall)
	);

	// A taken character that is not the last is followed by another one.
	`I2DA_ASSERT_NEXT(a_more_chars, clk, arst_n, chr_valid && !chr_stall && !chr.last_char, chr_valid)
	// A stalled character word stays valid and unchanged.
	`I2DA_ASSERT_NEXT(a_chr_hold, clk, arst_n, chr_valid && chr_stall, chr_valid && $stable(chr))
	// A number waiting at the serializer is neither lost nor dropped.
	`I2DA_ASSERT_NEXT(a_hold_pipe, clk, arst_n, emit_valid && emit_stall, emit_valid)
	// A minus sign never ends a number.
	`I2DA_ASSERT_IMPLY(a_sign_first, clk, arst_n, chr_valid && chr.char_out == i2da_pkg::CHAR_MINUS, !chr.last_char)

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives numbers into the decimal text converter and checks every character
// word against an in-bench formatter, under random and long output stalls.
// ----------------------------------------------------------------------------

module testbench;

	localparam int HALF_PERIOD = 5;
	localparam int MAX_REPORTS = 10;
	localparam int TAIL_CYCLES = 40;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                num_valid = 1'b0;
	i2da_pkg::in_word_t  num = '0;
	logic                num_stall;
	logic                chr_valid;
	i2da_pkg::out_word_t chr;
	logic                chr_stall = 1'b0;

	// Character words still owed by the block, oldest first.
	i2da_pkg::out_word_t pending_chars[$];
	int                  mismatch_count = 0;
	int                  send_gap_pct = 0;
	int                  recv_stall_pct = 0;
	int                  hold_off_left = 0;
	i2da_pkg::out_word_t owed_word;

	integer_to_decimal_ascii uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.num_valid (num_valid),
		.num       (num),
		.num_stall (num_stall),
		.chr_valid (chr_valid),
		.chr       (chr),
		.chr_stall (chr_stall)
	);

	always #HALF_PERIOD clk = ~clk;

	// Queue the decimal text of one accepted number, sign first, digits after.
	task automatic format_decimal(input i2da_pkg::in_word_t w);
		logic [31:0]         mag;
		logic                neg;
		int                  want;
		int                  ndig;
		logic [7:0]          rev[i2da_pkg::DIGITS];
		i2da_pkg::out_word_t word;
		want = (w.min_digits == 0) ? 1 : int'(w.min_digits);
		if (want > i2da_pkg::DIGITS) begin
			want = i2da_pkg::DIGITS;
		end
		neg = w.signed_mode && w.value_bits[31];
		mag = neg ? (~w.value_bits + 32'd1) : w.value_bits;
		ndig = 0;
		do begin
			rev[ndig] = i2da_pkg::CHAR_ZERO + 8'(mag % 32'd10);
			mag = mag / 32'd10;
			ndig++;
		end while ((mag != 0 || ndig < want) && ndig < i2da_pkg::DIGITS);
		if (neg) begin
			word.char_out = i2da_pkg::CHAR_MINUS;
			word.last_char = 1'b0;
			pending_chars.push_back(word);
		end
		for (int i = ndig - 1; i >= 0; i--) begin
			word.char_out = rev[i];
			word.last_char = (i == 0);
			pending_chars.push_back(word);
		end
	endtask

	// Offer one number after a random gap and hold it until it is taken.
	task automatic send_number(input logic [31:0] v, input logic sgn, input logic [3:0] mind);
		i2da_pkg::in_word_t w;
		w.value_bits = v;
		w.signed_mode = sgn;
		w.min_digits = mind;
		@(negedge clk);
		while ($urandom_range(99) < send_gap_pct) begin
			num_valid <= 1'b0;
			@(negedge clk);
		end
		num_valid <= 1'b1;
		num <= w;
		@(posedge clk);
		while (num_stall) begin
			@(posedge clk);
		end
		format_decimal(w);
	endtask

	// Stop offering numbers and wait until every owed character has come.
	task automatic wait_text_drained();
		@(negedge clk);
		num_valid <= 1'b0;
		while (pending_chars.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Value drawn from a mix of ranges that stress digit counts and the sign.
	function automatic logic [31:0] pick_value();
		logic [31:0] p;
		int          k;
		p = 32'd1;
		k = $urandom_range(9);
		case ($urandom_range(4))
			0: begin
				return $urandom;
			end
			1: begin
				return $urandom_range(999);
			end
			2: begin
				for (int i = 0; i < k; i++) begin
					p = p * 32'd10;
				end
				return p + $urandom_range(2) - 32'd1;
			end
			3: begin
				return -$urandom_range(1, 99999);
			end
			default: begin
				case ($urandom_range(4))
					0: return 32'h0000_0000;
					1: return 32'hFFFF_FFFF;
					2: return 32'h8000_0000;
					3: return 32'h7FFF_FFFF;
					default: return 32'h8000_0001;
				endcase
			end
		endcase
	endfunction

	// Extremes, padding limits, the most negative value and both modes.
	task automatic test_directed();
		send_number(32'd0, 1'b0, 4'd0);
		send_number(32'd0, 1'b1, 4'd10);
		send_number(32'd0, 1'b0, 4'd15);
		send_number(32'd7, 1'b0, 4'd11);
		send_number(32'hFFFF_FFFF, 1'b0, 4'd0);
		send_number(32'hFFFF_FFFF, 1'b1, 4'd0);
		send_number(32'hFFFF_FFFF, 1'b1, 4'd5);
		send_number(32'h8000_0000, 1'b1, 4'd0);
		send_number(32'h8000_0000, 1'b0, 4'd0);
		send_number(32'h7FFF_FFFF, 1'b1, 4'd1);
		send_number(32'h7FFF_FFFF, 1'b0, 4'd12);
		send_number(32'd9, 1'b0, 4'd1);
		send_number(32'd10, 1'b1, 4'd2);
		send_number(32'd99, 1'b0, 4'd3);
		send_number(32'd100, 1'b0, 4'd2);
		send_number(32'd999_999_999, 1'b1, 4'd0);
		send_number(32'd1_000_000_000, 1'b0, 4'd0);
		send_number(-32'd1_000_000_000, 1'b1, 4'd10);
		send_number(-32'd12345, 1'b1, 4'd8);
		send_number(32'd12345, 1'b1, 4'd4);
		send_number(32'hAAAA_5555, 1'b0, 4'd6);
		send_number(32'h5555_AAAA, 1'b1, 4'd9);
		wait_text_drained();
	endtask

	// Random numbers with random modes and minimum digit counts.
	task automatic test_random(input int count, input int gap_pct, input int stall_pct);
		send_gap_pct = gap_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < count; i++) begin
			send_number(pick_value(), 1'($urandom_range(1)), 4'($urandom_range(15)));
		end
		wait_text_drained();
	endtask

	// Output held off for a long stretch while numbers keep coming.
	task automatic test_backpressure();
		send_gap_pct = 0;
		recv_stall_pct = 0;
		hold_off_left = 250;
		for (int i = 0; i < 30; i++) begin
			send_number(pick_value(), 1'($urandom_range(1)), 4'($urandom_range(15)));
		end
		wait_text_drained();
	endtask

	// Receiver stall: held during a long hold-off that counts down, random otherwise.
	always @(negedge clk) begin
		if (hold_off_left > 0) begin
			chr_stall <= 1'b1;
			hold_off_left <= hold_off_left - 1;
		end else begin
			chr_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Compare each accepted character word with the oldest owed one.
	always @(posedge clk) begin
		if (arst_n && chr_valid && !chr_stall) begin
			if (pending_chars.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS) begin
					$display("unexpected word: char %h last %b", chr.char_out, chr.last_char);
				end
			end else begin
				owed_word = pending_chars.pop_front();
				if (chr.char_out !== owed_word.char_out
						|| chr.last_char !== owed_word.last_char) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS) begin
						$display("word mismatch: expected char %h last %b, got char %h last %b",
							owed_word.char_out, owed_word.last_char,
							chr.char_out, chr.last_char);
					end
				end
			end
		end
	end

	// Run the tests in turn, then let the pipeline settle before the verdict.
	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random(100, 24, 62);
		test_random(100, 62, 24);
		test_random(100, 0, 0);
		test_backpressure();
		wait_text_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_chars.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
